>>> sv/roirc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// roirc_pkg
// Shared widths, codes and types of the region row/column mean block.
// ----------------------------------------------------------------------------
package roirc_pkg;

    // Store geometry
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_AW     = $clog2(MAX_WIDTH);

    // Field widths
    localparam int PIX_W      = 16;
    localparam int POS_W      = 12;
    localparam int DIM_W      = 13;
    localparam int MODE_W     = 2;
    localparam int SUM_W      = 28;
    localparam int MEAN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_HEIGHT  = 3'd5;

    // Mode codes; any other code gives both kinds
    localparam logic [MODE_W-1:0] MODE_COL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROW  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOTH = 2'd2;

    // Result kinds
    localparam logic KIND_ROW = 1'b0;
    localparam logic KIND_COL = 1'b1;

    // Register reset values
    localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(MAX_HEIGHT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_DIV,
        S_PUT
    } t_state;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [DIM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [MEAN_W-1:0] quot;
    } t_div_rsp;

    // Force a dimension into 1..hi
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/roirc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// roirc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module roirc_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> sv/roirc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// roirc_div
// Restoring divider, one quotient bit per cycle, floor(sum / count).
// ----------------------------------------------------------------------------
module roirc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  roirc_pkg::t_div_req i_req,
    output roirc_pkg::t_div_rsp o_rsp
);
    import roirc_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_q;
    logic [DIM_W-1:0] r_rem;
    logic [DIM_W-1:0] r_div;

    logic [DIM_W:0]   rem_sh;
    logic [DIM_W:0]   rem_sub;
    logic             ge;

    // One restoring step
    always_comb begin
        rem_sh  = {r_rem, r_q[SUM_W-1]};
        ge      = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift in one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[SUM_W-2:0], ge};
            r_rem <= ge ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q[MEAN_W-1:0];

endmodule
`default_nettype wire

>>> sv/roi_row_column_mean_core.sv
`default_nettype none
// Flow: a pixel that ends no mean passes accept and the column read-modify-write (S_UPD).
// A pixel that ends one mean starts the divider in S_UPD, waits in S_DIV, then in S_PUT loads
// the mean into the output register and frees the input; the last region pixel with both means runs the divider twice.
// Each mean takes a pass of the one-bit-per-cycle divider; one pixel is in work at a time.
// Reset (i_rst_n low, synchronous) returns the registers to their defaults and the
// position and row sum to zero; the column store is not cleared, the first region row fills it.
// ----------------------------------------------------------------------------
// roi_row_column_mean_core
// Region of interest row and column mean over a raster pixel stream; the
// column sums live in one RAM, updated by read-modify-write.
// ----------------------------------------------------------------------------
module roi_row_column_mean_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Pixel input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [roirc_pkg::PIX_W-1:0]      i_pixel,
    input  logic                             i_frame_start,
    // Result output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_kind,
    output logic [roirc_pkg::POS_W-1:0]      o_index,
    output logic [roirc_pkg::MEAN_W-1:0]     o_mean,
    output logic                             o_last,
    // Register write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [roirc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [roirc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import roirc_pkg::*;

    localparam int EXT_W = POS_W + 2;

    // Configuration
    logic [MODE_W-1:0] r_mode;
    logic [DIM_W-1:0]  r_frame_width;
    logic [POS_W-1:0]  r_roi_x;
    logic [POS_W-1:0]  r_roi_y;
    logic [DIM_W-1:0]  r_roi_width;
    logic [DIM_W-1:0]  r_roi_height;
    logic [DIM_W-1:0]  fw_c;
    logic [DIM_W-1:0]  rw_c;
    logic [DIM_W-1:0]  rh_c;
    logic              want_col;
    logic              want_row;

    // Control
    t_state            r_state;
    t_state            n_state;
    logic              r_col_pend;
    logic              r_row_pend;
    logic [POS_W-1:0]  r_pos_x;
    logic [POS_W-1:0]  r_pos_y;
    logic [SUM_W-1:0]  r_row_sum;

    // Current word
    logic [POS_W-1:0]  r_x;
    logic [POS_W-1:0]  r_y;
    logic [PIX_W-1:0]  r_pix;

    // Output register
    logic              r_out_valid;
    logic              r_out_kind;
    logic [POS_W-1:0]  r_out_index;
    logic [MEAN_W-1:0] r_out_mean;
    logic              r_out_last;

    // Accept and position
    logic              in_acc;
    logic [POS_W-1:0]  cur_x;
    logic [POS_W-1:0]  cur_y;
    logic [DIM_W-1:0]  nx_x;
    logic [DIM_W-1:0]  nx_y;
    logic [POS_W-1:0]  n_pos_x;
    logic [POS_W-1:0]  n_pos_y;

    // Update stage
    logic [EXT_W-1:0]  x_e;
    logic [EXT_W-1:0]  y_e;
    logic [EXT_W-1:0]  x_beg;
    logic [EXT_W-1:0]  y_beg;
    logic [EXT_W-1:0]  x_end;
    logic [EXT_W-1:0]  y_end;
    logic              in_roi;
    logic              col_hit;
    logic              row_hit;
    logic [SUM_W-1:0]  ram_rdata;
    logic [SUM_W-1:0]  col_new;
    logic [SUM_W-1:0]  row_new;

    // Sequencer outputs
    logic              out_free;
    logic              out_load;
    logic              ram_we;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    // Clamp the dimensions
    always_comb begin
        fw_c     = clamp_dim(r_frame_width, DIM_MAX_W);
        rw_c     = clamp_dim(r_roi_width, DIM_MAX_W);
        rh_c     = clamp_dim(r_roi_height, DIM_MAX_H);
        want_col = (r_mode != MODE_ROW);
        want_row = (r_mode != MODE_COL);
    end

    // Register writes; always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_BOTH;
            r_frame_width <= DIM_MAX_W;
            r_roi_x       <= '0;
            r_roi_y       <= '0;
            r_roi_width   <= DIM_MAX_W;
            r_roi_height  <= DIM_MAX_H;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MODE:        r_mode        <= i_cfg_data[MODE_W-1:0];
                CFG_FRAME_WIDTH: r_frame_width <= i_cfg_data[DIM_W-1:0];
                CFG_ROI_X:       r_roi_x       <= i_cfg_data[POS_W-1:0];
                CFG_ROI_Y:       r_roi_y       <= i_cfg_data[POS_W-1:0];
                CFG_ROI_WIDTH:   r_roi_width   <= i_cfg_data[DIM_W-1:0];
                CFG_ROI_HEIGHT:  r_roi_height  <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Position of the incoming word and the raster advance
    always_comb begin
        in_acc  = i_in_valid && !o_in_stall;
        cur_x   = i_frame_start ? '0 : r_pos_x;
        cur_y   = i_frame_start ? '0 : r_pos_y;
        nx_x    = {1'b0, cur_x} + DIM_W'(1);
        nx_y    = {1'b0, cur_y} + DIM_W'(1);
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        if (in_acc) begin
            if (nx_x >= fw_c) begin
                n_pos_x = '0;
                n_pos_y = (nx_y >= DIM_MAX_H) ? '0 : nx_y[POS_W-1:0];
            end else begin
                n_pos_x = nx_x[POS_W-1:0];
                n_pos_y = cur_y;
            end
        end
    end

    // Region test and new sums for the word in the update cycle
    always_comb begin
        x_e     = EXT_W'(r_x);
        y_e     = EXT_W'(r_y);
        x_beg   = EXT_W'(r_roi_x);
        y_beg   = EXT_W'(r_roi_y);
        x_end   = x_beg + EXT_W'(rw_c);
        y_end   = y_beg + EXT_W'(rh_c);
        in_roi  = (x_e >= x_beg) && (x_e < x_end) && (y_e >= y_beg) && (y_e < y_end);
        col_hit = in_roi && want_col && (y_e == y_end - EXT_W'(1));
        row_hit = in_roi && want_row && (x_e == x_end - EXT_W'(1));
        col_new = (r_y == r_roi_y) ? SUM_W'(r_pix) : ram_rdata + SUM_W'(r_pix);
        row_new = (r_x == r_roi_x) ? SUM_W'(r_pix) : r_row_sum + SUM_W'(r_pix);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = (col_hit || row_hit) ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_state = (r_col_pend && r_row_pend) ? S_DIV : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        out_free         = !r_out_valid || !i_out_stall;
        o_in_stall       = (r_state != S_IDLE);
        ram_we           = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_row_sum;
        div_req.divisor  = rw_c;
        unique case (r_state)
            S_IDLE: begin
            end
            S_UPD: begin
                ram_we           = in_roi;
                div_req.start    = col_hit || row_hit;
                div_req.dividend = col_hit ? col_new : row_new;
                div_req.divisor  = col_hit ? rh_c : rw_c;
            end
            S_DIV: begin
            end
            S_PUT: begin
                out_load      = out_free;
                div_req.start = out_free && r_col_pend && r_row_pend;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col_pend  <= 1'b0;
            r_row_pend  <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_row_sum   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            if (r_state == S_UPD) begin
                r_col_pend <= col_hit;
                r_row_pend <= row_hit;
                if (in_roi) begin
                    r_row_sum <= row_new;
                end
            end else if (out_load) begin
                // drop the pending mean that goes out now; column first
                if (r_col_pend) begin
                    r_col_pend <= 1'b0;
                end else begin
                    r_row_pend <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Word and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x   <= cur_x;
            r_y   <= cur_y;
            r_pix <= i_pixel;
        end
        if (out_load) begin
            r_out_kind  <= r_col_pend ? KIND_COL : KIND_ROW;
            r_out_index <= r_col_pend ? r_x : r_y;
            r_out_mean  <= div_rsp.quot;
            r_out_last  <= r_col_pend ? !r_row_pend : 1'b1;
        end
    end

    // Column store: read on accept, write back in the update cycle. Only one
    // word is in work, so a read never overlaps a pending write of the same entry.
    roirc_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_x[COL_AW-1:0]),
        .i_wdata (col_new),
        .i_re    (in_acc),
        .i_raddr (cur_x[COL_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Shared divider for row and column means
    roirc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_index     = r_out_index;
    assign o_mean      = r_out_mean;
    assign o_last      = r_out_last;

endmodule
`default_nettype wire

>>> sv/roirc_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// roirc_chk
// Port-level checks of the region row/column mean core, bound to the top.
// ----------------------------------------------------------------------------
module roirc_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic                        o_kind,
    input wire logic [roirc_pkg::POS_W-1:0] o_index,
    input wire logic [roirc_pkg::MEAN_W-1:0] o_mean,
    input wire logic                        o_last
);
    import roirc_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) &&
        $stable(o_index) && $stable(o_mean) && $stable(o_last))
        else $error("stalled result word changed");

    // One pixel in work at a time
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted in back-to-back cycles");

    // A row mean always closes the results of its pixel
    a_row_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_ROW) |-> o_last)
        else $error("row mean without last");

    // A column mean followed by a row mean keeps the input stalled
    a_col_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_COL) && !o_last |-> o_in_stall)
        else $error("input open while a row mean is still due");

endmodule

bind roi_row_column_mean_core roirc_chk u_roirc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_kind      (o_kind),
    .o_index     (o_index),
    .o_mean      (o_mean),
    .o_last      (o_last)
);
`default_nettype wire

>>> verif/tb_roi_row_column_mean_core.sv
// ----------------------------------------------------------------------------
// tb_roi_row_column_mean_core
// Self-checking bench for the region row/column mean core. It streams raster
// frames through the pixel port under several register settings, predicts
// every row and column mean at the moment a pixel word is taken, and checks
// each mean word in order. Both ports idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_roi_row_column_mean_core;

    import roirc_pkg::*;

    localparam int IDLE_LIMIT   = 4000;  // cycles with no word moved
    localparam int SETTLE_LEN   = 70;    // covers the longest pixel, the one with both means
    localparam int HOLD_LEN     = 600;   // one long receiver hold-off
    localparam int RANDOM_ITEMS = 750;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pix_word_t;

    typedef struct packed {
        logic              kind;
        logic [POS_W-1:0]  index;
        logic [MEAN_W-1:0] mean;
        logic              last;
    } mean_word_t;

    // Clock, reset and block inputs
    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  in_valid       = 1'b0;
    logic [PIX_W-1:0]      in_pixel       = '0;
    logic                  in_frame_start = 1'b0;
    logic                  out_stall      = 1'b0;
    logic                  cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = CFG_MODE;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_kind;
    logic [POS_W-1:0]      o_index;
    logic [MEAN_W-1:0]     o_mean;
    logic                  o_last;
    logic                  o_cfg_ready;

    // Pixel words waiting to be offered, and means still owed by the block
    pix_word_t  pending_pixels[$];
    mean_word_t expected_means[$];
    int         err_count = 0;

    // Register shadow, at reset values
    logic [MODE_W-1:0] reg_mode         = MODE_BOTH;
    logic [DIM_W-1:0]  reg_frame_width  = DIM_MAX_W;
    logic [POS_W-1:0]  reg_roi_x        = '0;
    logic [POS_W-1:0]  reg_roi_y        = '0;
    logic [DIM_W-1:0]  reg_roi_width    = DIM_MAX_W;
    logic [DIM_W-1:0]  reg_roi_height   = DIM_MAX_H;

    // Raster position and sums of the predictor
    int unsigned       scan_x   = 0;
    int unsigned       scan_y   = 0;
    logic [SUM_W-1:0]  line_sum = '0;
    logic [SUM_W-1:0]  column_acc [MAX_WIDTH];

    // Traffic shaping
    logic quiet      = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;
    int   send_gap   = 0;
    int   send_calm_left = 0;
    logic send_calm  = 1'b0;
    int   recv_gap   = 0;
    int   recv_calm_left = 0;
    logic recv_calm  = 1'b0;
    int   idle_cycles = 0;

    roi_row_column_mean_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel       (in_pixel),
        .i_frame_start (in_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_kind        (o_kind),
        .o_index       (o_index),
        .o_mean        (o_mean),
        .o_last        (o_last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #4 clk = ~clk;

    // Zero counts as one, anything above the limit as the limit
    function automatic int unsigned effective_dim(input logic [DIM_W-1:0] v,
                                                  input int unsigned hi);
        if (v == '0) return 1;
        if (32'(v) > hi) return hi;
        return 32'(v);
    endfunction

    // Advance the raster by one pixel and queue the means it completes
    function automatic void predict_means(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned       fw, rw, rh, x, y, rx, ry;
        logic              col_done, row_done, want_col, want_row;
        logic [MEAN_W-1:0] col_mean, row_mean;
        mean_word_t        m;
        fw = effective_dim(reg_frame_width, MAX_WIDTH);
        rw = effective_dim(reg_roi_width, MAX_WIDTH);
        rh = effective_dim(reg_roi_height, MAX_HEIGHT);
        rx = 32'(reg_roi_x);
        ry = 32'(reg_roi_y);
        want_col = (reg_mode != MODE_ROW);
        want_row = (reg_mode != MODE_COL);
        col_done = 1'b0;
        row_done = 1'b0;
        col_mean = '0;
        row_mean = '0;
        if (fs) begin
            scan_x = 0;
            scan_y = 0;
        end
        x = scan_x;
        y = scan_y;
        if (x >= rx && x < rx + rw && y >= ry && y < ry + rh) begin
            // first region row overwrites the column entry, later rows add
            if (y == ry) begin
                column_acc[COL_AW'(x)] = SUM_W'(pix);
            end else begin
                column_acc[COL_AW'(x)] = column_acc[COL_AW'(x)] + SUM_W'(pix);
            end
            if (x == rx) begin
                line_sum = SUM_W'(pix);
            end else begin
                line_sum = line_sum + SUM_W'(pix);
            end
            if (y == ry + rh - 1) begin
                col_done = 1'b1;
                col_mean = MEAN_W'(column_acc[COL_AW'(x)] / rh);
            end
            if (x == rx + rw - 1) begin
                row_done = 1'b1;
                row_mean = MEAN_W'(line_sum / rw);
            end
        end
        // column mean goes out ahead of the row mean
        if (col_done && want_col) begin
            m.kind  = KIND_COL;
            m.index = POS_W'(x);
            m.mean  = col_mean;
            m.last  = !(row_done && want_row);
            expected_means.push_back(m);
        end
        if (row_done && want_row) begin
            m.kind  = KIND_ROW;
            m.index = POS_W'(y);
            m.mean  = row_mean;
            m.last  = 1'b1;
            expected_means.push_back(m);
        end
        if (x + 1 >= fw) begin
            scan_x = 0;
            scan_y = (y + 1 >= MAX_HEIGHT) ? 0 : y + 1;
        end else begin
            scan_x = x + 1;
        end
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Queue n pixels, the first one marking a frame start
    task automatic push_run(input int unsigned n, input int fill);
        pix_word_t w;
        for (int unsigned k = 0; k < n; k++) begin
            w.pixel       = (fill < 0) ? rand_pixel() : PIX_W'(fill);
            w.frame_start = (k == 0);
            pending_pixels.push_back(w);
        end
    endtask

    // One register write; the block is idle, so update the shadow on the handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(posedge clk); while (o_cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:        reg_mode        = MODE_W'(val);
            CFG_FRAME_WIDTH: reg_frame_width = DIM_W'(val);
            CFG_ROI_X:       reg_roi_x       = POS_W'(val);
            CFG_ROI_Y:       reg_roi_y       = POS_W'(val);
            CFG_ROI_WIDTH:   reg_roi_width   = DIM_W'(val);
            CFG_ROI_HEIGHT:  reg_roi_height  = DIM_W'(val);
            default: ;
        endcase
    endtask

    task automatic set_regs(input int unsigned mode_v, input int unsigned fw_v,
                            input int unsigned rx_v, input int unsigned ry_v,
                            input int unsigned rw_v, input int unsigned rh_v);
        write_reg(CFG_MODE, mode_v);
        write_reg(CFG_FRAME_WIDTH, fw_v);
        write_reg(CFG_ROI_X, rx_v);
        write_reg(CFG_ROI_Y, ry_v);
        write_reg(CFG_ROI_WIDTH, rw_v);
        write_reg(CFG_ROI_HEIGHT, rh_v);
        @(negedge clk);
    endtask

    // Wait until every pixel is taken and every mean is back, then let the block settle
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_pixels.size() != 0 || in_valid || expected_means.size() != 0);
        repeat (SETTLE_LEN) @(negedge clk);
    endtask

    // Pixel driver: offer the next word once the current one is taken
    always @(posedge clk) begin : drive_pixels
        pix_word_t word;
        logic      next_valid;
        next_valid = in_valid;
        if (send_calm_left == 0) begin
            send_calm_left = $urandom_range(20, 200);
            send_calm      = ($urandom_range(0, 2) == 0);
        end else begin
            send_calm_left--;
        end
        if (!rst_n) begin
            next_valid = 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            next_valid = 1'b0;
            if (send_gap != 0) begin
                send_gap--;
            end else if (pending_pixels.size() != 0) begin
                if (!quiet && !send_calm && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 7);
                end else begin
                    word = pending_pixels.pop_front();
                    in_pixel       <= word.pixel;
                    in_frame_start <= word.frame_start;
                    next_valid = 1'b1;
                end
            end
        end
        in_valid <= next_valid;
    end

    // Result receiver: random stall bursts plus one long hold-off on request
    always @(posedge clk) begin : drive_stall
        logic next_stall;
        next_stall = 1'b0;
        if (recv_calm_left == 0) begin
            recv_calm_left = $urandom_range(20, 200);
            recv_calm      = ($urandom_range(0, 2) == 0);
        end else begin
            recv_calm_left--;
        end
        if (!rst_n) begin
            next_stall = 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_LEN;
            next_stall = 1'b1;
        end else if (hold_left != 0) begin
            hold_left--;
            next_stall = 1'b1;
        end else if (recv_gap != 0) begin
            recv_gap--;
            next_stall = 1'b1;
        end else if (!quiet && !recv_calm && $urandom_range(0, 5) == 0) begin
            recv_gap   = $urandom_range(0, 7);
            next_stall = 1'b1;
        end
        out_stall <= next_stall;
    end

    // Monitor: predict on each taken pixel, check each taken mean word
    always @(posedge clk) begin : watch_ports
        mean_word_t got, want;
        if (rst_n) begin
            if (in_valid && !o_in_stall) begin
                predict_means(in_pixel, in_frame_start);
            end
            if (o_out_valid && !out_stall) begin
                got.kind  = o_kind;
                got.index = o_index;
                got.mean  = o_mean;
                got.last  = o_last;
                if (expected_means.size() == 0) begin
                    err_count++;
                    $display("%0t expected no mean, actual kind=%0d index=%0d mean=%0d last=%0d",
                             $time, got.kind, got.index, got.mean, got.last);
                end else begin
                    want = expected_means.pop_front();
                    if (got.kind !== want.kind || got.index !== want.index ||
                        got.mean !== want.mean || got.last !== want.last) begin
                        err_count++;
                        // fields as kind/index/mean/last
                        $display("%0t mismatch: expected %0d/%0d/%0d/%0d, actual %0d/%0d/%0d/%0d",
                                 $time, want.kind, want.index, want.mean, want.last,
                                 got.kind, got.index, got.mean, got.last);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on any port for too long
    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t watchdog: no word moved for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus
    initial begin : stimulus
        int unsigned fw, rx, ry, rw, rh, n, k, mode_v, random_items, phase_no;
        random_items = 0;
        phase_no     = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: a stretch of brightest pixels, no mean completes
        push_run(48, 65535);
        wait_drained();

        // Small region inside a 4x4 frame; last region pixel ends both means
        set_regs(MODE_BOTH, 4, 1, 1, 2, 2);
        push_run(16, -1);
        wait_drained();

        // Mode three with a one-row region (height zero counts as one)
        set_regs(3, 3, 0, 0, 3, 0);
        push_run(3, -1);
        wait_drained();

        // Column means only, region width zero counts as one, dark pixels
        set_regs(MODE_COL, 2, 0, 0, 0, 2);
        push_run(4, 0);
        wait_drained();

        // Row means only, region wider than the frame: no row mean ever
        set_regs(MODE_ROW, 3, 1, 0, 8191, 1);
        push_run(6, -1);
        wait_drained();

        // Row means only, region height clamps to the maximum
        set_regs(MODE_ROW, 2, 0, 1, 2, 8191);
        push_run(6, -1);
        wait_drained();

        // Frame width clamps to the maximum; one-column, one-row region mid-line
        set_regs(MODE_BOTH, 8191, 7, 0, 1, 1);
        push_run(24, -1);
        wait_drained();

        // Frame width zero counts as one: every pixel starts a row
        set_regs(MODE_BOTH, 0, 0, 20, 1, 1);
        push_run(24, -1);
        wait_drained();

        // Random settings with mostly whole frames, some cut short, some noise
        while (random_items < RANDOM_ITEMS) begin
            fw = $urandom_range(1, 12);
            rx = ($urandom_range(0, 7) == 0) ? fw : $urandom_range(0, fw - 1);
            mode_v = $urandom_range(0, 3);
            rw = $urandom_range(1, fw - rx + 1);
            ry = $urandom_range(0, 3);
            rh = $urandom_range(1, 4);
            // the hold-off phase gets a row mean at the end of every region row
            if (phase_no == 1) begin
                rx     = 0;
                mode_v = MODE_BOTH;
                rw     = fw;
                rh     = 4;
            end
            set_regs(mode_v, (fw == 1 && $urandom_range(0, 1) == 0) ? 0 : fw, rx, ry,
                     (rw == 1 && $urandom_range(0, 1) == 0) ? 0 : rw,
                     (rh == 1 && $urandom_range(0, 1) == 0) ? 0 : rh);
            if (phase_no == 1) begin
                hold_req = 1'b1;
            end
            if (random_items > RANDOM_ITEMS * 5 / 6) begin
                quiet = 1'b1;
            end
            repeat ($urandom_range(1, 3)) begin
                n = fw * (ry + rh + $urandom_range(0, 1));
                if (phase_no != 1 && $urandom_range(0, 4) == 0) begin
                    n = $urandom_range(1, n);
                end
                push_run(n, -1);
                random_items += n;
                // trailing noise: stray pixels, some restarting the frame
                if ($urandom_range(0, 3) == 0) begin
                    k = $urandom_range(1, 6);
                    repeat (k) begin
                        pending_pixels.push_back('{pixel: rand_pixel(),
                                                   frame_start: ($urandom_range(0, 3) == 0)});
                    end
                    random_items += k;
                end
            end
            phase_no++;
            wait_drained();
        end

        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
